// ----- src/tccw_pkg.sv -----
// Text console cell writer: shared types and constants.
// Used by the controller, the top level and the checker; depends on nothing.
package tccw_pkg;

  localparam int OPCODE_W = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int ROW_IN_W = 5;
  localparam int COL_IN_W = 7;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h70;
  localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h7020;
  // blank of a scrolled-in row: gray fg 12 on bg 7
  localparam logic [CELL_W-1:0]  SCROLL_BLANK = {4'd7, 4'd12, SPACE_CODE};
  // blank of clear screen / clear line: white fg 15 on bg 0
  localparam logic [CELL_W-1:0]  CLEAR_BLANK  = {4'd0, 4'd15, SPACE_CODE};

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT_CHAR     = 3'd0,
    OP_PUT_CELL     = 3'd1,
    OP_SET_CURSOR   = 3'd2,
    OP_CLEAR_SCREEN = 3'd3,
    OP_CLEAR_LINE   = 3'd4,
    OP_READ_CELL    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  cell_color;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] column;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
  } res_t;

endpackage

// ----- src/tccw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/tccw_ctrl.sv -----
// Text console controller: sequencer, cursor, and sweep over the cell RAM
// (clear pass, fills, scroll copy). Depends on tccw_pkg.
module tccw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      item_valid,
  output logic                                      item_ready,
  input  tccw_pkg::item_t                           item,
  input  logic [tccw_pkg::COLOR_W-1:0]              text_color,
  output logic                                      res_valid,
  input  logic                                      res_ready,
  output tccw_pkg::res_t                            res,
  output logic                                      wr_en,
  output logic [$clog2(ROWS*COLUMNS)-1:0]           wr_addr,
  output logic [tccw_pkg::CELL_W-1:0]               wr_data,
  output logic                                      rd_en,
  output logic [$clog2(ROWS*COLUMNS)-1:0]           rd_addr,
  input  logic [tccw_pkg::CELL_W-1:0]               rd_data
);

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

  tccw_pkg::state_t state, state_next;
  tccw_pkg::item_t  item_q;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_end;
  logic [tccw_pkg::CELL_W-1:0] fill_value;
  logic [tccw_pkg::CELL_W-1:0] value_q;
  logic              copy_pending;
  logic [ADDR_W-1:0] copy_addr;

  logic [ROW_W+tccw_pkg::ROW_IN_W-1:0] row_ext;
  logic [COL_W+tccw_pkg::COL_IN_W-1:0] col_ext;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              row_ok, col_ok, in_bounds;
  logic              is_newline, last_row, last_col;
  logic [ADDR_W-1:0] tgt_addr, line_addr, cur_addr;
  logic [ADDR_W+tccw_pkg::POS_W-1:0] pos_wide;
  tccw_pkg::op_t     op;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(r) * ROW_SPAN + ADDR_W'(c);
  endfunction

  assign op         = tccw_pkg::op_t'(item_q.opcode);
  assign row_ok     = int'(item_q.row) < ROWS;
  assign col_ok     = int'(item_q.column) < COLUMNS;
  assign in_bounds  = row_ok && col_ok;
  assign row_ext    = {{ROW_W{1'b0}}, item_q.row};
  assign col_ext    = {{COL_W{1'b0}}, item_q.column};
  assign in_row     = row_ext[ROW_W-1:0];
  assign in_col     = col_ext[COL_W-1:0];
  assign tgt_addr   = cell_addr(in_row, in_col);
  assign line_addr  = cell_addr(in_row, '0);
  assign cur_addr   = cell_addr(cur_row, cur_col);
  assign is_newline = item_q.char_code == tccw_pkg::NEWLINE_CODE;
  assign last_row   = cur_row == ROW_LAST;
  assign last_col   = cur_col == COL_LAST;
  assign pos_wide   = {{tccw_pkg::POS_W{1'b0}}, cur_addr};

  assign res.cursor_position = pos_wide[tccw_pkg::POS_W-1:0];
  assign res.cell_value      = value_q;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tccw_pkg::ST_INIT: begin
        if (sweep_addr == LAST_ADDR) state_next = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (item_valid) state_next = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        case (op)
          tccw_pkg::OP_PUT_CHAR: begin
            if ((is_newline || last_col) && last_row) state_next = tccw_pkg::ST_COPY;
            else state_next = tccw_pkg::ST_DONE;
          end
          tccw_pkg::OP_CLEAR_SCREEN: state_next = tccw_pkg::ST_FILL;
          tccw_pkg::OP_CLEAR_LINE:
            state_next = row_ok ? tccw_pkg::ST_FILL : tccw_pkg::ST_DONE;
          tccw_pkg::OP_READ_CELL:
            state_next = in_bounds ? tccw_pkg::ST_READ : tccw_pkg::ST_DONE;
          default: state_next = tccw_pkg::ST_DONE;
        endcase
      end
      tccw_pkg::ST_READ: state_next = tccw_pkg::ST_DONE;
      tccw_pkg::ST_COPY: begin
        if (sweep_addr == COPY_LAST) state_next = tccw_pkg::ST_DRAIN;
      end
      tccw_pkg::ST_DRAIN: state_next = tccw_pkg::ST_FILL;
      tccw_pkg::ST_FILL: begin
        if (sweep_addr == sweep_end) state_next = tccw_pkg::ST_DONE;
      end
      tccw_pkg::ST_DONE: begin
        if (res_ready) state_next = tccw_pkg::ST_IDLE;
      end
      default: state_next = tccw_pkg::ST_INIT;
    endcase
  end

  // outputs and RAM port control
  always_comb begin
    item_ready = state == tccw_pkg::ST_IDLE;
    res_valid  = state == tccw_pkg::ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = sweep_addr;
    wr_data    = fill_value;
    rd_en      = 1'b0;
    rd_addr    = sweep_addr + ROW_SPAN;
    if (copy_pending) begin
      // scroll: data read in the previous cycle lands one row up
      wr_en   = 1'b1;
      wr_addr = copy_addr;
      wr_data = rd_data;
    end else begin
      case (state)
        tccw_pkg::ST_INIT: begin
          wr_en   = 1'b1;
          wr_data = tccw_pkg::RESET_CELL;
        end
        tccw_pkg::ST_FILL: wr_en = 1'b1;
        tccw_pkg::ST_EXEC: begin
          if (op == tccw_pkg::OP_PUT_CHAR && !is_newline) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {text_color, item_q.char_code};
          end else if (op == tccw_pkg::OP_PUT_CELL && in_bounds) begin
            wr_en   = 1'b1;
            wr_addr = tgt_addr;
            wr_data = {item_q.cell_color, item_q.char_code};
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
    if (state == tccw_pkg::ST_COPY) begin
      rd_en = 1'b1;
    end else if (state == tccw_pkg::ST_EXEC && op == tccw_pkg::OP_READ_CELL && in_bounds) begin
      rd_en   = 1'b1;
      rd_addr = tgt_addr;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tccw_pkg::ST_INIT;
      sweep_addr   <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      copy_pending <= 1'b0;
    end else begin
      state        <= state_next;
      copy_pending <= state == tccw_pkg::ST_COPY;
      case (state)
        tccw_pkg::ST_INIT, tccw_pkg::ST_COPY, tccw_pkg::ST_FILL: begin
          sweep_addr <= sweep_addr + 1'b1;
        end
        tccw_pkg::ST_EXEC: begin
          case (op)
            tccw_pkg::OP_PUT_CHAR: begin
              if (is_newline || last_col) begin
                cur_col    <= '0;
                sweep_addr <= '0;
                if (!last_row) cur_row <= cur_row + 1'b1;
              end else begin
                cur_col <= cur_col + 1'b1;
              end
            end
            tccw_pkg::OP_SET_CURSOR: begin
              cur_row <= row_ok ? in_row : ROW_LAST;
              cur_col <= col_ok ? in_col : COL_LAST;
            end
            tccw_pkg::OP_CLEAR_SCREEN: begin
              cur_row    <= '0;
              cur_col    <= '0;
              sweep_addr <= '0;
            end
            tccw_pkg::OP_CLEAR_LINE: sweep_addr <= line_addr;
            default: sweep_addr <= sweep_addr;
          endcase
        end
        default: sweep_addr <= sweep_addr;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_addr <= sweep_addr;
    case (state)
      tccw_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_q  <= item;
          value_q <= '0;
        end
      end
      tccw_pkg::ST_EXEC: begin
        if (op == tccw_pkg::OP_CLEAR_SCREEN) begin
          sweep_end  <= LAST_ADDR;
          fill_value <= tccw_pkg::CLEAR_BLANK;
        end else if (op == tccw_pkg::OP_CLEAR_LINE) begin
          sweep_end  <= line_addr + ROW_SPAN - 1'b1;
          fill_value <= tccw_pkg::CLEAR_BLANK;
        end
      end
      tccw_pkg::ST_READ: value_q <= rd_data;
      tccw_pkg::ST_DRAIN: begin
        // bottom row follows the copy
        sweep_end  <= LAST_ADDR;
        fill_value <= tccw_pkg::SCROLL_BLANK;
      end
      default: value_q <= value_q;
    endcase
  end

endmodule

// ----- src/text_console_cell_writer.sv -----
// Text console cell writer, top level: attribute register, result register,
// controller and cell RAM. Depends on tccw_pkg, tccw_ctrl and tccw_ram.
//
// Accepts one command at a time. Read cell passes through a RAM read state
// when the position is on screen; clear line fills one row (no fill when
// the row is off screen); clear screen fills the whole RAM; a put char that
// scrolls copies every row but the top one up a row and then blanks the
// bottom row, the copy and the blank row going through the single RAM write
// port one cell a cycle. After reset the same port walks the RAM once and
// in_ready stays low; configuration writes are taken at any time. A finished
// result waits in the output register, so the next command may be taken
// before it is read out; the result after that holds the controller until
// the register is emptied.
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tccw_pkg::COLOR_W-1:0]        text_color,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tccw_pkg::OPCODE_W-1:0]       opcode,
  input  logic [tccw_pkg::CHAR_W-1:0]         char_code,
  input  logic [tccw_pkg::COLOR_W-1:0]        cell_color,
  input  logic [tccw_pkg::ROW_IN_W-1:0]       row,
  input  logic [tccw_pkg::COL_IN_W-1:0]       column,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tccw_pkg::POS_W-1:0]          cursor_position,
  output logic [tccw_pkg::CELL_W-1:0]         cell_value
);

  localparam int ADDR_W = $clog2(ROWS * COLUMNS);

  logic [tccw_pkg::COLOR_W-1:0] text_attr;
  tccw_pkg::item_t item;
  tccw_pkg::res_t  res;
  logic res_valid, res_ready;
  logic wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [tccw_pkg::CELL_W-1:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= tccw_pkg::RESET_COLOR;
    end else if (cfg_valid) begin
      text_attr <= text_color;
    end
  end

  assign item.opcode     = opcode;
  assign item.char_code  = char_code;
  assign item.cell_color = cell_color;
  assign item.row        = row;
  assign item.column     = column;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cursor_position <= res.cursor_position;
      cell_value      <= res.cell_value;
    end
  end

  tccw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(in_valid),
    .item_ready(in_ready),
    .item      (item),
    .text_color(text_attr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tccw_ram #(
    .WIDTH(tccw_pkg::CELL_W),
    .DEPTH(ROWS * COLUMNS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

// ----- src/tccw_checker.sv -----
// Port-level checks for the text console cell writer, bound to the top level.
// Depends on tccw_pkg and text_console_cell_writer.
module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tccw_pkg::POS_W-1:0]    cursor_position,
  input logic [tccw_pkg::CELL_W-1:0]   cell_value
);

  localparam int DEPTH = ROWS * COLUMNS;

  // clearing pass after reset holds off commands
  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // one command in flight: no back-to-back transfers
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one still running");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_position) && $stable(cell_value))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 2048) || (int'(cursor_position) < DEPTH))
    else $error("cursor position beyond screen");

endmodule

bind text_console_cell_writer tccw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .cursor_position(cursor_position),
  .cell_value     (cell_value)
);
